>>> rtl/core/rv32_subset_instruction_step_core_macros.svh
// Assertion helpers shared by the core's top level.
`ifndef RV32_SUBSET_INSTRUCTION_STEP_CORE_MACROS_SVH
`define RV32_SUBSET_INSTRUCTION_STEP_CORE_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define RV32S_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed: same-cycle implication");

// Next-cycle implication.
`define RV32S_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed: next-cycle implication");

`endif

>>> rtl/core/rv32s_pkg.sv
package rv32s_pkg;

	localparam int MEM_ADDR_BITS = 20;
	localparam int QUEUE_DEPTH = 2;
	localparam int QUEUE_PTR_BITS = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int QUEUE_CNT_BITS = $clog2(QUEUE_DEPTH + 1);

	localparam logic OPC_WRITE = 1'b0;

	localparam logic [6:0] OP_REG   = 7'b0110011;
	localparam logic [6:0] OP_IMM   = 7'b0010011;
	localparam logic [6:0] OP_LUI   = 7'b0110111;
	localparam logic [6:0] OP_JALR  = 7'b1100111;
	localparam logic [6:0] OP_LOAD  = 7'b0000011;
	localparam logic [6:0] OP_STORE = 7'b0100011;
	localparam logic [31:0] INST_EBREAK = 32'h0010_0073;
	localparam logic [31:0] UPPER_MASK = 32'hFFFF_F000;

	localparam logic [2:0] F3_ZERO = 3'd0;
	localparam logic [2:0] F3_WORD = 3'd2;
	localparam logic [2:0] F3_BYTE_U = 3'd4;
	localparam logic [4:0] REG_A0 = 5'd10;
	localparam logic [4:0] REG_ZERO = 5'd0;

	typedef enum logic [1:0] {
		TRAP_NONE = 2'd0,
		TRAP_GOOD = 2'd1,
		TRAP_BAD  = 2'd2
	} trap_kind_t;

	typedef enum logic {
		KIND_WRITE,
		KIND_STEP
	} item_kind_t;

	typedef struct packed {
		logic        opcode;
		logic [19:0] byte_address;
		logic [7:0]  byte_value;
	} in_item_t;

	typedef struct packed {
		logic [31:0]        next_pc;
		logic               is_halted;
		trap_kind_t         trap_kind;
		logic signed [31:0] exit_value;
	} out_item_t;

	typedef struct packed {
		item_kind_t               kind;
		logic [MEM_ADDR_BITS-1:0] addr;
		logic [7:0]               value;
	} q_item_t;

	typedef struct packed {
		logic    valid;
		q_item_t item;
	} q_link_t;

	typedef enum logic [2:0] {
		BK_IDLE,
		BK_FETCH,
		BK_DEC,
		BK_EXEC,
		BK_LOAD,
		BK_LDWB,
		BK_STORE,
		BK_DONE
	} bk_state_t;

	function automatic logic [31:0] sext12(input logic [11:0] v);
		return {{20{v[11]}}, v};
	endfunction

	// Merge a byte that is still in flight from the memory into a buffer.
	function automatic logic [31:0] merge_byte(input logic [31:0] buf_v, input logic pend,
		input logic [1:0] idx, input logic [7:0] data);
		logic [31:0] r;
		r = buf_v;
		if (pend) begin
			r[idx*8 +: 8] = data;
		end
		return r;
	endfunction

endpackage

>>> rtl/core/rv32_subset_instruction_step_core.sv
// Small RV32 core (ADD, ADDI, LUI, JALR, LW, LBU, SW, SB, EBREAK) over a byte-wide
// memory of 2**MEM_ADDR_BITS bytes. Each transfer on the input either writes one
// memory byte or executes one instruction, and each gives exactly one result
// transfer with the PC, halt flag and trap report. A two-entry queue takes items
// while the executing side works. The single memory port sets the timing: a byte
// write goes straight to its result; an instruction takes four byte fetches,
// decode, execute and result, and loads and stores add one memory access per byte.
// A step after a halt skips the fetch. No clearing pass is needed after reset.
`include "rv32_subset_instruction_step_core_macros.svh"

module rv32_subset_instruction_step_core (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  rv32s_pkg::in_item_t  in_item,
	output logic                 out_valid,
	input  logic                 out_ready,
	output rv32s_pkg::out_item_t out_item
);

	rv32s_pkg::q_link_t q_link;
	logic               q_pop;

	// Front end: accepts each transfer, sorts it into a byte write or a step, queues it.
	rv32s_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_item  (in_item),
		.q_link   (q_link),
		.q_pop    (q_pop)
	);

	// Back end: memory, register file and the execution sequencer with its result register.
	rv32s_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_link    (q_link),
		.q_pop     (q_pop),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_item  (out_item)
	);

	// A trap is reported exactly when the core is halted.
	`RV32S_ASSERT_NOW(a_trap_iff_halt, out_valid,
		out_item.is_halted == (out_item.trap_kind != rv32s_pkg::TRAP_NONE))
	// While running, the exit value is zero.
	`RV32S_ASSERT_NOW(a_exit_zero, out_valid && !out_item.is_halted, out_item.exit_value == '0)
	// The back end never takes an item from an empty queue.
	`RV32S_ASSERT_NOW(a_pop_nonempty, q_pop, q_link.valid)

endmodule

>>> rtl/core/rv32s_front.sv
module rv32s_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  rv32s_pkg::in_item_t in_item,
	output rv32s_pkg::q_link_t  q_link,
	input  logic                q_pop
);

	rv32s_pkg::q_item_t                         fifo_q [rv32s_pkg::QUEUE_DEPTH];
	logic [rv32s_pkg::QUEUE_PTR_BITS-1:0]       wr_ptr_q;
	logic [rv32s_pkg::QUEUE_PTR_BITS-1:0]       rd_ptr_q;
	logic [rv32s_pkg::QUEUE_CNT_BITS-1:0]       count_q;
	rv32s_pkg::q_item_t                         classified;
	logic                                       push;
	logic                                       pop;

	always_comb begin
		classified.kind = (in_item.opcode == rv32s_pkg::OPC_WRITE) ?
			rv32s_pkg::KIND_WRITE : rv32s_pkg::KIND_STEP;
		classified.addr = rv32s_pkg::MEM_ADDR_BITS'(in_item.byte_address);
		classified.value = in_item.byte_value;
	end

	assign in_ready = (count_q != rv32s_pkg::QUEUE_CNT_BITS'(rv32s_pkg::QUEUE_DEPTH));
	assign push = in_valid && in_ready;
	assign pop = q_pop && (count_q != '0);
	assign q_link.valid = (count_q != '0);
	assign q_link.item = fifo_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_ptr_q] <= classified;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == rv32s_pkg::QUEUE_PTR_BITS'(rv32s_pkg::QUEUE_DEPTH - 1)) ?
					'0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == rv32s_pkg::QUEUE_PTR_BITS'(rv32s_pkg::QUEUE_DEPTH - 1)) ?
					'0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

>>> rtl/core/rv32s_back.sv
module rv32s_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  rv32s_pkg::q_link_t   q_link,
	output logic                 q_pop,
	output logic                 out_valid,
	input  logic                 out_ready,
	output rv32s_pkg::out_item_t out_item
);

	localparam int AW = rv32s_pkg::MEM_ADDR_BITS;

	logic [7:0]  mem [2**AW];
	logic [7:0]  mem_rdata_q;
	logic        mem_we;
	logic [AW-1:0] mem_addr;
	logic [7:0]  mem_wdata;
	logic        mem_re;

	logic [31:0] rf [32];
	logic [31:0] rf_v_q;
	logic [31:0] rd1_q;
	logic [31:0] rd2_q;
	logic        rv1_q;
	logic        rv2_q;
	logic        rf_re;
	logic        rf_we;
	logic [4:0]  rf_wa;
	logic [31:0] rf_wd;

	rv32s_pkg::bk_state_t state_q;
	rv32s_pkg::bk_state_t state_d;
	logic [1:0]  cnt_q;
	logic [1:0]  last_q;
	logic        pend_q;
	logic [1:0]  pidx_q;
	logic [31:0] buf_q;
	logic [31:0] inst_q;
	logic [31:0] pc_q;
	logic        halt_q;
	logic [31:0] a0_q;
	logic [31:0] ad_q;
	logic        out_vq;
	rv32s_pkg::out_item_t out_q;
	logic        out_load;

	logic [31:0] buf_now;
	logic [31:0] opa;
	logic [31:0] opb;
	logic [6:0]  op;
	logic [2:0]  f3;
	logic [6:0]  f7;
	logic [4:0]  rd;
	logic [31:0] imm_i;
	logic [31:0] imm_s;
	logic [31:0] pc4;
	logic        is_add;
	logic        is_addi;
	logic        is_lui;
	logic        is_jalr;
	logic        is_lw;
	logic        is_lbu;
	logic        is_sw;
	logic        is_sb;
	logic        is_ebreak;

	assign buf_now = rv32s_pkg::merge_byte(buf_q, pend_q, pidx_q, mem_rdata_q);
	assign opa = rv1_q ? rd1_q : '0;
	assign opb = rv2_q ? rd2_q : '0;
	assign op = inst_q[6:0];
	assign rd = inst_q[11:7];
	assign f3 = inst_q[14:12];
	assign f7 = inst_q[31:25];
	assign imm_i = rv32s_pkg::sext12(inst_q[31:20]);
	assign imm_s = rv32s_pkg::sext12({inst_q[31:25], inst_q[11:7]});
	assign pc4 = pc_q + 32'd4;

	assign is_add = (op == rv32s_pkg::OP_REG) && (f3 == rv32s_pkg::F3_ZERO) && (f7 == 7'd0);
	assign is_addi = (op == rv32s_pkg::OP_IMM) && (f3 == rv32s_pkg::F3_ZERO);
	assign is_lui = (op == rv32s_pkg::OP_LUI);
	assign is_jalr = (op == rv32s_pkg::OP_JALR) && (f3 == rv32s_pkg::F3_ZERO);
	assign is_lw = (op == rv32s_pkg::OP_LOAD) && (f3 == rv32s_pkg::F3_WORD);
	assign is_lbu = (op == rv32s_pkg::OP_LOAD) && (f3 == rv32s_pkg::F3_BYTE_U);
	assign is_sw = (op == rv32s_pkg::OP_STORE) && (f3 == rv32s_pkg::F3_WORD);
	assign is_sb = (op == rv32s_pkg::OP_STORE) && (f3 == rv32s_pkg::F3_ZERO);
	assign is_ebreak = (inst_q == rv32s_pkg::INST_EBREAK);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rv32s_pkg::BK_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		q_pop = 1'b0;
		mem_we = 1'b0;
		mem_re = 1'b0;
		mem_addr = AW'(pc_q + 32'(cnt_q));
		mem_wdata = q_link.item.value;
		rf_re = 1'b0;
		rf_we = 1'b0;
		rf_wa = rd;
		rf_wd = '0;
		out_load = 1'b0;
		unique case (state_q)
			rv32s_pkg::BK_IDLE: begin
				if (q_link.valid) begin
					q_pop = 1'b1;
					if (q_link.item.kind == rv32s_pkg::KIND_WRITE) begin
						mem_we = 1'b1;
						mem_addr = q_link.item.addr;
						state_d = rv32s_pkg::BK_DONE;
					end else if (halt_q) begin
						state_d = rv32s_pkg::BK_DONE;
					end else begin
						state_d = rv32s_pkg::BK_FETCH;
					end
				end
			end
			rv32s_pkg::BK_FETCH: begin
				mem_re = 1'b1;
				if (cnt_q == 2'd3) begin
					state_d = rv32s_pkg::BK_DEC;
				end
			end
			rv32s_pkg::BK_DEC: begin
				rf_re = 1'b1;
				state_d = rv32s_pkg::BK_EXEC;
			end
			rv32s_pkg::BK_EXEC: begin
				priority if (is_add) begin
					rf_we = (rd != rv32s_pkg::REG_ZERO);
					rf_wd = opa + opb;
					state_d = rv32s_pkg::BK_DONE;
				end else if (is_addi) begin
					rf_we = (rd != rv32s_pkg::REG_ZERO);
					rf_wd = opa + imm_i;
					state_d = rv32s_pkg::BK_DONE;
				end else if (is_lui) begin
					rf_we = (rd != rv32s_pkg::REG_ZERO);
					rf_wd = inst_q & rv32s_pkg::UPPER_MASK;
					state_d = rv32s_pkg::BK_DONE;
				end else if (is_jalr) begin
					rf_we = (rd != rv32s_pkg::REG_ZERO);
					rf_wd = pc4;
					state_d = rv32s_pkg::BK_DONE;
				end else if (is_lw || is_lbu) begin
					state_d = rv32s_pkg::BK_LOAD;
				end else if (is_sw || is_sb) begin
					state_d = rv32s_pkg::BK_STORE;
				end else begin
					state_d = rv32s_pkg::BK_DONE;
				end
			end
			rv32s_pkg::BK_LOAD: begin
				mem_re = 1'b1;
				mem_addr = AW'(ad_q + 32'(cnt_q));
				if (cnt_q == last_q) begin
					state_d = rv32s_pkg::BK_LDWB;
				end
			end
			rv32s_pkg::BK_LDWB: begin
				rf_we = (rd != rv32s_pkg::REG_ZERO);
				rf_wd = buf_now;
				state_d = rv32s_pkg::BK_DONE;
			end
			rv32s_pkg::BK_STORE: begin
				mem_we = 1'b1;
				mem_addr = AW'(ad_q + 32'(cnt_q));
				mem_wdata = opb[cnt_q*8 +: 8];
				if (cnt_q == last_q) begin
					state_d = rv32s_pkg::BK_DONE;
				end
			end
			rv32s_pkg::BK_DONE: begin
				if (!out_vq || out_ready) begin
					out_load = 1'b1;
					state_d = rv32s_pkg::BK_IDLE;
				end
			end
			default: begin
				state_d = rv32s_pkg::BK_IDLE;
			end
		endcase
	end

	// Byte memory: one port, registered read data.
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_addr] <= mem_wdata;
		end
		if (mem_re) begin
			mem_rdata_q <= mem[mem_addr];
		end
	end

	// Register file: two registered read ports, one write port.
	always_ff @(posedge clk) begin
		if (rf_we) begin
			rf[rf_wa] <= rf_wd;
		end
		if (rf_re) begin
			rd1_q <= rf[buf_now[19:15]];
			rd2_q <= rf[buf_now[24:20]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rf_v_q <= '0;
			rv1_q <= 1'b0;
			rv2_q <= 1'b0;
			a0_q <= '0;
		end else begin
			if (rf_we) begin
				rf_v_q[rf_wa] <= 1'b1;
				if (rf_wa == rv32s_pkg::REG_A0) begin
					a0_q <= rf_wd;
				end
			end
			if (rf_re) begin
				rv1_q <= rf_v_q[buf_now[19:15]];
				rv2_q <= rf_v_q[buf_now[24:20]];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= '0;
			halt_q <= 1'b0;
			pend_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			pend_q <= mem_re;
			if ((state_q == rv32s_pkg::BK_FETCH) || (state_q == rv32s_pkg::BK_LOAD) ||
				(state_q == rv32s_pkg::BK_STORE)) begin
				cnt_q <= cnt_q + 2'd1;
			end else begin
				cnt_q <= '0;
			end
			// Unknown instructions match none of these and leave the PC where it is.
			if (state_q == rv32s_pkg::BK_EXEC) begin
				if (is_jalr) begin
					pc_q <= (opa + imm_i) & ~32'd1;
				end else if (is_add || is_addi || is_lui || is_lw || is_lbu || is_sw || is_sb) begin
					pc_q <= pc4;
				end else if (is_ebreak) begin
					halt_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		pidx_q <= cnt_q;
		if (state_q == rv32s_pkg::BK_EXEC) begin
			buf_q <= '0;
			ad_q <= opa + ((is_sw || is_sb) ? imm_s : imm_i);
			last_q <= (is_lw || is_sw) ? 2'd3 : 2'd0;
		end else begin
			buf_q <= buf_now;
		end
		if (state_q == rv32s_pkg::BK_DEC) begin
			inst_q <= buf_now;
		end
		if (out_load) begin
			out_q.next_pc <= pc_q;
			out_q.is_halted <= halt_q;
			out_q.trap_kind <= !halt_q ? rv32s_pkg::TRAP_NONE :
				((a0_q == '0) ? rv32s_pkg::TRAP_GOOD : rv32s_pkg::TRAP_BAD);
			out_q.exit_value <= halt_q ? $signed(a0_q) : '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vq <= 1'b0;
		end else if (out_load) begin
			out_vq <= 1'b1;
		end else if (out_ready) begin
			out_vq <= 1'b0;
		end
	end

	assign out_valid = out_vq;
	assign out_item = out_q;

endmodule
